// ===== hw/rtl/amb_pkg.sv =====
// Shared types and constants for the adjacency matrix graph traversal block.
package amb_pkg;

	// Field widths fixed by the item format.
	localparam int VW     = 6;
	localparam int OP_W   = 2;
	localparam int CFG_W  = 7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_BFS    = 2'd2;
	localparam logic [OP_W-1:0] OP_DFS    = 2'd3;

	// Row memory read address selects.
	localparam logic [1:0] RSEL_A    = 2'd0;
	localparam logic [1:0] RSEL_B    = 2'd1;
	localparam logic [1:0] RSEL_LIST = 2'd2;
	localparam logic [1:0] RSEL_TOP  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       row_rd;
		logic [1:0] row_sel;
		logic       row_wr;
		logic       wr_sel_b;
		logic       trav_init;
		logic       list_rd_head;
		logic       cand_load;
		logic       bfs_push;
		logic       dfs_push;
		logic       dfs_pop;
		logic       top_load;
		logic       finish;
	} amb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            edge_ok;
		logic            start_ok;
		logic            head_eq_tail;
		logic            cand_zero;
		logic            sp_one;
		logic            out_free;
	} amb_sts_t;

endpackage

// ===== hw/rtl/amb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module amb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/amb_ctrl.sv =====
// Controller state machine that sequences edge updates and traversals.
module amb_ctrl import amb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  amb_sts_t sts,
	output amb_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_E_RDA  = 4'd2;
	localparam logic [3:0] S_E_WRA  = 4'd3;
	localparam logic [3:0] S_E_RDB  = 4'd4;
	localparam logic [3:0] S_E_WRB  = 4'd5;
	localparam logic [3:0] S_T_INIT = 4'd6;
	localparam logic [3:0] S_B_POP  = 4'd7;
	localparam logic [3:0] S_B_WAIT = 4'd8;
	localparam logic [3:0] S_B_CAND = 4'd9;
	localparam logic [3:0] S_B_SCAN = 4'd10;
	localparam logic [3:0] S_D_RD   = 4'd11;
	localparam logic [3:0] S_D_CAND = 4'd12;
	localparam logic [3:0] S_D_STEP = 4'd13;
	localparam logic [3:0] S_D_POPW = 4'd14;
	localparam logic [3:0] S_FIN    = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.op == OP_ADD || sts.op == OP_REMOVE) begin
					state_d = sts.edge_ok ? S_E_RDA : S_IDLE;
				end else begin
					state_d = sts.start_ok ? S_T_INIT : S_IDLE;
				end
			end
			S_E_RDA: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = RSEL_A;
				state_d     = S_E_WRA;
			end
			S_E_WRA: begin
				cmd.row_wr = 1'b1;
				state_d    = S_E_RDB;
			end
			S_E_RDB: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = RSEL_B;
				state_d     = S_E_WRB;
			end
			S_E_WRB: begin
				cmd.row_wr   = 1'b1;
				cmd.wr_sel_b = 1'b1;
				state_d      = S_IDLE;
			end
			S_T_INIT: begin
				cmd.trav_init = 1'b1;
				state_d       = (sts.op == OP_BFS) ? S_B_POP : S_D_RD;
			end
			S_B_POP: begin
				if (sts.head_eq_tail) begin
					state_d = S_FIN;
				end else begin
					cmd.list_rd_head = 1'b1;
					state_d          = S_B_WAIT;
				end
			end
			S_B_WAIT: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = RSEL_LIST;
				state_d     = S_B_CAND;
			end
			S_B_CAND: begin
				cmd.cand_load = 1'b1;
				state_d       = S_B_SCAN;
			end
			S_B_SCAN: begin
				if (sts.cand_zero) begin
					state_d = S_B_POP;
				end else if (sts.out_free) begin
					cmd.bfs_push = 1'b1;
				end
			end
			S_D_RD: begin
				cmd.row_rd  = 1'b1;
				cmd.row_sel = RSEL_TOP;
				state_d     = S_D_CAND;
			end
			S_D_CAND: begin
				cmd.cand_load = 1'b1;
				state_d       = S_D_STEP;
			end
			S_D_STEP: begin
				if (!sts.cand_zero) begin
					if (sts.out_free) begin
						cmd.dfs_push = 1'b1;
						state_d      = S_D_RD;
					end
				end else if (sts.sp_one) begin
					state_d = S_FIN;
				end else begin
					cmd.dfs_pop = 1'b1;
					state_d     = S_D_POPW;
				end
			end
			S_D_POPW: begin
				cmd.top_load = 1'b1;
				state_d      = S_D_RD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/amb_dpath.sv =====
// Datapath: adjacency rows, visit list, visited marks, scan mask and result register.
module amb_dpath import amb_pkg::*; #(
	parameter int MAX_VERTEX_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [OP_W-1:0]   op,
	input  logic [VW-1:0]     vertex_a,
	input  logic [VW-1:0]     vertex_b,
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  vertex_count,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [VW-1:0]     visited_vertex,
	output logic              last,
	input  amb_cmd_t          cmd,
	output amb_sts_t          sts
);

	localparam int N  = MAX_VERTEX_COUNT;
	localparam int AW = $clog2(N);

	logic [OP_W-1:0]  op_q;
	logic [VW-1:0]    a_q;
	logic [VW-1:0]    b_q;
	logic [CFG_W-1:0] vc_q;
	logic [CFG_W-1:0] n_eff;
	logic [N-1:0]     nmask;
	logic [N-1:0]     rv_q;
	logic             row_ok_q;
	logic [N-1:0]     row_rdata;
	logic [N-1:0]     row_eff;
	logic [N-1:0]     row_wdata;
	logic [AW-1:0]    row_raddr;
	logic [AW-1:0]    row_waddr;
	logic [VW-1:0]    list_rdata;
	logic [VW-1:0]    list_wdata;
	logic [AW-1:0]    list_waddr;
	logic [AW-1:0]    list_raddr;
	logic             list_we;
	logic [N-1:0]     visited_q;
	logic [N-1:0]     cand_q;
	logic [CFG_W-1:0] head_q;
	logic [CFG_W-1:0] tail_q;
	logic [CFG_W-1:0] sp_q;
	logic [VW-1:0]    top_q;
	logic [VW-1:0]    pend_q;
	logic [VW-1:0]    pick;
	logic [N-1:0]     pick_bit;
	logic             out_free;
	logic             emit;

	// Effective vertex count and the mask of vertices in use.
	assign n_eff = (vc_q > CFG_W'(N)) ? CFG_W'(N) : vc_q;
	always_comb begin
		for (int i = 0; i < N; i++) begin
			nmask[i] = (CFG_W'(i) < n_eff);
		end
	end

	// Lowest pending neighbor of the scan mask.
	always_comb begin
		pick = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (cand_q[i]) begin
				pick = VW'(i);
			end
		end
	end
	assign pick_bit = {{(N-1){1'b0}}, 1'b1} << pick;

	// Adjacency row memory; rows never written read as zero.
	always_comb begin
		case (cmd.row_sel)
			RSEL_A:    row_raddr = a_q[AW-1:0];
			RSEL_B:    row_raddr = b_q[AW-1:0];
			RSEL_LIST: row_raddr = list_rdata[AW-1:0];
			RSEL_TOP:  row_raddr = top_q[AW-1:0];
			default:   row_raddr = a_q[AW-1:0];
		endcase
	end
	assign row_eff   = row_ok_q ? row_rdata : '0;
	assign row_waddr = cmd.wr_sel_b ? b_q[AW-1:0] : a_q[AW-1:0];
	always_comb begin
		logic [N-1:0] bit_m;
		bit_m = {{(N-1){1'b0}}, 1'b1} << (cmd.wr_sel_b ? a_q : b_q);
		row_wdata = (op_q == OP_ADD) ? (row_eff | bit_m) : (row_eff & ~bit_m);
	end

	amb_ram #(.WIDTH(N), .DEPTH(N)) u_rows (
		.clk   (clk),
		.we    (cmd.row_wr),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	// Visit list: the queue for breadth first, the stack for depth first.
	// The start vertex always goes to entry zero.
	always_comb begin
		list_we    = cmd.trav_init | cmd.bfs_push | cmd.dfs_push;
		list_waddr = cmd.trav_init ? '0 : (cmd.bfs_push ? tail_q[AW-1:0] : sp_q[AW-1:0]);
		list_wdata = cmd.trav_init ? a_q : pick;
		list_raddr = cmd.dfs_pop ? AW'(sp_q - CFG_W'(2)) : head_q[AW-1:0];
	end

	amb_ram #(.WIDTH(VW), .DEPTH(N)) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	assign out_free = !out_valid || !out_stall;
	assign emit     = cmd.bfs_push | cmd.dfs_push | cmd.finish;

	// Status to the controller.
	always_comb begin
		sts.op           = op_q;
		sts.edge_ok      = ({1'b0, a_q} < n_eff) && ({1'b0, b_q} < n_eff);
		sts.start_ok     = ({1'b0, a_q} < n_eff);
		sts.head_eq_tail = (head_q == tail_q);
		sts.cand_zero    = (cand_q == '0);
		sts.sp_one       = (sp_q == CFG_W'(1));
		sts.out_free     = out_free;
	end

	// Item latch and traversal payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			a_q  <= vertex_a;
			b_q  <= vertex_b;
		end
		if (cmd.trav_init) begin
			visited_q <= {{(N-1){1'b0}}, 1'b1} << a_q;
			top_q     <= a_q;
			pend_q    <= a_q;
		end
		if (cmd.cand_load) begin
			cand_q <= row_eff & ~visited_q & nmask;
		end else if (cmd.bfs_push) begin
			cand_q <= cand_q & ~pick_bit;
		end
		if (cmd.bfs_push || cmd.dfs_push) begin
			visited_q <= visited_q | pick_bit;
			pend_q    <= pick;
		end
		if (cmd.dfs_push) begin
			top_q <= pick;
		end else if (cmd.top_load) begin
			top_q <= list_rdata;
		end
		if (emit) begin
			visited_vertex <= pend_q;
			last           <= cmd.finish;
		end
	end

	// Control registers: configuration, row valid bits, list pointers, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= CFG_W'(64);
			rv_q      <= '0;
			row_ok_q  <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vc_q <= vertex_count;
			end
			if (cmd.row_wr) begin
				rv_q[row_waddr] <= 1'b1;
			end
			if (cmd.row_rd) begin
				row_ok_q <= rv_q[row_raddr];
			end
			if (cmd.trav_init) begin
				head_q <= '0;
				tail_q <= CFG_W'(1);
				sp_q   <= CFG_W'(1);
			end else begin
				if (cmd.list_rd_head) begin
					head_q <= head_q + CFG_W'(1);
				end
				if (cmd.bfs_push) begin
					tail_q <= tail_q + CFG_W'(1);
				end
				if (cmd.dfs_push) begin
					sp_q <= sp_q + CFG_W'(1);
				end else if (cmd.dfs_pop) begin
					sp_q <= sp_q - CFG_W'(1);
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/adjacency_matrix_bfs_dfs_top.sv =====
// Top level of the adjacency matrix graph store with breadth and depth first traversal.
// An add or remove item goes through decode, then a row read and write for each endpoint,
// and gives no result. A traversal goes through decode and setup, then every step waits
// on a registered adjacency row read: breadth first pops a vertex, reads its row, loads
// the scan mask, gives one result per cycle while the result side does not stall, and
// ends the scan; depth first does a row read and scan per descent, and a pop plus a fresh
// row read on every return; both end with the final result. Stalls on the result side
// hold the traversal. One item is worked on at a time and the input stalls until it is
// done; results wait in an output register, and the last result of a traversal carries
// last high.
module adjacency_matrix_bfs_dfs_top import amb_pkg::*; #(
	parameter int MAX_VERTEX_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [OP_W-1:0]  op,
	input  logic [VW-1:0]    vertex_a,
	input  logic [VW-1:0]    vertex_b,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] vertex_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VW-1:0]    visited_vertex,
	output logic             last
);

	amb_cmd_t cmd;
	amb_sts_t sts;

	// Configuration transactions are always taken.
	assign cfg_ready = 1'b1;

	amb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	amb_dpath #(.MAX_VERTEX_COUNT(MAX_VERTEX_COUNT)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.cfg_valid      (cfg_valid),
		.vertex_count   (vertex_count),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.visited_vertex (visited_vertex),
		.last           (last),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

// ===== sim/adj_traversal_checker.sv =====
// Checker that predicts and compares the visit order of the graph traversal block.
module adj_traversal_checker import amb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [OP_W-1:0]  op,
	input  logic [VW-1:0]    vertex_a,
	input  logic [VW-1:0]    vertex_b,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] vertex_count,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [VW-1:0]    visited_vertex,
	input  logic             last,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic          last;
	} visit_t;

	// Shadow copy of the graph and the vertex count register.
	logic [63:0]      graph_rows [64];
	logic [CFG_W-1:0] shadow_count;
	visit_t           visit_order [$];

	assign pending = visit_order.size();

	// Prints one mismatch line and counts it.
	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Marks the final visit of the traversal that was just predicted.
	task automatic close_walk(input int first_idx);
		visit_t tail;
		if (visit_order.size() > first_idx) begin
			tail = visit_order[$];
			tail.last = 1'b1;
			visit_order[visit_order.size() - 1] = tail;
		end
	endtask

	// Breadth first order, neighbours in ascending index.
	task automatic walk_breadth(input int start, input int n);
		logic [VW-1:0] fifo [64];
		logic [63:0]   seen;
		int            head;
		int            tail;
		int            u;
		seen = 64'd1 << start;
		fifo[0] = start[VW-1:0];
		head = 0;
		tail = 1;
		while (head < tail) begin
			u = fifo[head];
			head++;
			visit_order.push_back('{vertex: u[VW-1:0], last: 1'b0});
			for (int v = 0; v < n; v++) begin
				if (graph_rows[u][v] && !seen[v] && tail < 64) begin
					seen[v] = 1'b1;
					fifo[tail] = v[VW-1:0];
					tail++;
				end
			end
		end
	endtask

	// Depth first order on an explicit stack of vertex and resume index.
	task automatic walk_depth(input int start, input int n);
		int          stk_vertex [64];
		int          stk_next [64];
		logic [63:0] seen;
		int          sp;
		int          u;
		int          j;
		bit          found;
		seen = 64'd1 << start;
		visit_order.push_back('{vertex: start[VW-1:0], last: 1'b0});
		stk_vertex[0] = start;
		stk_next[0] = 0;
		sp = 1;
		while (sp > 0) begin
			u = stk_vertex[sp - 1];
			found = 1'b0;
			for (j = stk_next[sp - 1]; j < n; j++) begin
				if (graph_rows[u][j] && !seen[j]) begin
					found = 1'b1;
					break;
				end
			end
			if (found && sp < 64) begin
				stk_next[sp - 1] = j + 1;
				seen[j] = 1'b1;
				visit_order.push_back('{vertex: j[VW-1:0], last: 1'b0});
				stk_vertex[sp] = j;
				stk_next[sp] = 0;
				sp++;
			end else begin
				sp--;
			end
		end
	endtask

	// Applies one accepted input transaction to the shadow graph or predicts its visits.
	task automatic predict_item(input logic [OP_W-1:0] code, input int a, input int b);
		int n;
		int first_idx;
		n = (shadow_count > 64) ? 64 : int'(shadow_count);
		first_idx = visit_order.size();
		case (code)
			OP_ADD: begin
				if (a < n && b < n) begin
					graph_rows[a][b] = 1'b1;
					graph_rows[b][a] = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (a < n && b < n) begin
					graph_rows[a][b] = 1'b0;
					graph_rows[b][a] = 1'b0;
				end
			end
			OP_BFS: begin
				if (a < n) walk_breadth(a, n);
			end
			default: begin
				if (a < n) walk_depth(a, n);
			end
		endcase
		close_walk(first_idx);
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		visit_t want;
		if (!arst_n) begin
			for (int r = 0; r < 64; r++) graph_rows[r] = '0;
			shadow_count = 7'd64;
			visit_order.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (visit_order.size() == 0) begin
					report($sformatf("unexpected result vertex %0d", visited_vertex));
				end else begin
					want = visit_order.pop_front();
					if (visited_vertex !== want.vertex)
						report($sformatf("visited_vertex %0d, expected %0d",
							visited_vertex, want.vertex));
					if (last !== want.last)
						report($sformatf("last %0b, expected %0b at vertex %0d",
							last, want.last, want.vertex));
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_count = vertex_count;
			if (in_valid && !in_stall)
				predict_item(op, int'(vertex_a), int'(vertex_b));
		end
	end

endmodule

// ===== sim/tb_adjacency_matrix_bfs_dfs_top.sv =====
// Testbench top that drives the graph traversal block and gives the verdict.
module tb_adjacency_matrix_bfs_dfs_top;
	import amb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [OP_W-1:0]  op;
	logic [VW-1:0]    vertex_a;
	logic [VW-1:0]    vertex_b;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] vertex_count;
	logic             out_valid;
	logic             out_stall;
	logic [VW-1:0]    visited_vertex;
	logic             last;
	int               fail_count;
	int               pending;
	int               stall_left;
	int               quiet_cycles;
	bit               tx_steady;
	bit               rx_steady;
	int               active_n;

	adjacency_matrix_bfs_dfs_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.vertex_count   (vertex_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.visited_vertex (visited_vertex),
		.last           (last)
	);

	adj_traversal_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.vertex_count   (vertex_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.visited_vertex (visited_vertex),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Clock with a period of 20.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side stalls a random number of cycles after each transaction.
	always @(posedge clk or negedge arst_n) begin
		int d;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			d = rx_steady ? 0 : $urandom_range(0, 16);
			stall_left <= d;
			out_stall <= (d != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Sends one input transaction after a random gap.
	task automatic send_item(input logic [OP_W-1:0] code, input int a, input int b);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= code;
		vertex_a <= a[VW-1:0];
		vertex_b <= b[VW-1:0];
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Holds the sender until every expected result is in and the block is idle.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Writes the vertex count register; the block must be idle.
	task automatic write_count(input int value);
		drain();
		vertex_count <= value[CFG_W-1:0];
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		active_n = (value > 64) ? 64 : value;
	endtask

	// Mostly vertices in use, sometimes anything the field holds.
	function automatic int pick_vertex();
		if (active_n == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 63);
		return $urandom_range(0, active_n - 1);
	endfunction

	// Random item: mostly edge edits, with traversals mixed in.
	task automatic send_random;
		int r;
		logic [OP_W-1:0] code;
		r = $urandom_range(0, 99);
		if (r < 55) code = OP_ADD;
		else if (r < 68) code = OP_REMOVE;
		else if (r < 84) code = OP_BFS;
		else code = OP_DFS;
		send_item(code, pick_vertex(), pick_vertex());
	endtask

	initial begin
		int counts [10] = '{16, 1, 0, 127, 8, 64, 3, 32, 5, 64};
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		vertex_a = '0;
		vertex_b = '0;
		cfg_valid = 1'b0;
		vertex_count = 7'd64;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		active_n = 64;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full graph size, extreme vertices, self loop, removal.
		write_count(64);
		send_item(OP_BFS, 0, 0);
		send_item(OP_ADD, 0, 63);
		send_item(OP_ADD, 0, 1);
		send_item(OP_ADD, 1, 62);
		send_item(OP_ADD, 5, 5);
		send_item(OP_ADD, 62, 63);
		send_item(OP_ADD, 5, 62);
		send_item(OP_BFS, 0, 63);
		send_item(OP_DFS, 0, 42);
		send_item(OP_REMOVE, 63, 0);
		send_item(OP_BFS, 63, 0);
		send_item(OP_DFS, 5, 21);
		send_item(OP_DFS, 63, 63);

		// Directed: shrunken count ignores and hides vertices beyond it.
		write_count(8);
		send_item(OP_ADD, 9, 2);
		send_item(OP_ADD, 2, 63);
		send_item(OP_ADD, 1, 7);
		send_item(OP_BFS, 40, 0);
		send_item(OP_DFS, 8, 0);
		send_item(OP_BFS, 1, 0);
		send_item(OP_DFS, 0, 0);
		send_item(OP_REMOVE, 7, 7);
		send_item(OP_DFS, 7, 0);

		// Random phases across several vertex counts.
		foreach (counts[p]) begin
			write_count(counts[p]);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			repeat (21) send_random();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
